@@ rtl/rhh_pkg.sv @@
package rhh_pkg;

    // Capacity must be a power of two: the home slot is the low bits of the hash.
    localparam int CAPACITY    = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = SLOT_W + 1;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_PUT    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
        logic [SLOT_W-1:0]      probe;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ rtl/rhh_ram.sv @@
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/robin_hood_hash_table.sv @@
// Each probed or shifted slot takes one read state and one evaluate state, and
// an entry state and an exit state come before and after them.
// An unused op code visits no slot.
// One transaction at a time; each slot needs a memory read before it can be
// evaluated, and that sets the pace.
// Reset (synchronous, active low) clears all occupancy bits and the entry count
// at once; the table is usable in the next cycle.
module robin_hood_hash_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // key[31:0], value[63:32], fallback_value[95:64], hash_value[127:96]
    input  logic [127:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // read_value[31:0], entry_count[38:32], zero[39]
    output logic [39:0]  o_m_axis_tdata,
    // success[0]
    output logic         o_m_axis_tuser
);
    import rhh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EV   = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [1:0]             r_op;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [31:0]            r_fb;
    logic [SLOT_W-1:0]      r_slot, n_slot, r_a, n_a;
    logic [CNT_W-1:0]       r_off, n_off, r_kd, n_kd, r_cnt, n_cnt;
    logic                   r_shift, n_shift;
    logic                   r_ok, n_ok;
    logic [31:0]            r_rv, n_rv;
    logic [CAPACITY-1:0]    r_valid, n_valid;
    logic                   r_mvalid;
    logic [31:0]            r_m_rv;
    logic [CNT_W-1:0]       r_m_cnt;
    logic                   r_m_ok;

    logic                   we;
    logic [SLOT_W-1:0]      waddr;
    t_entry                 wdata, rd;
    logic [ENTRY_W-1:0]     rdata;
    logic                   empty;
    logic [CNT_W-1:0]       d;
    logic                   load_out;

    rhh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_slot),
        .o_rdata (rdata)
    );

    assign rd    = t_entry'(rdata);
    assign empty = !r_valid[r_slot];
    assign d     = {1'b0, rd.probe};

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign load_out        = (r_state == S_DONE) && (!r_mvalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_val   = r_val;
        n_slot  = r_slot;
        n_a     = r_a;
        n_off   = r_off;
        n_kd    = r_kd;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_ok    = r_ok;
        n_rv    = r_rv;
        n_valid = r_valid;
        we      = 1'b0;
        waddr   = r_slot;
        wdata   = rd;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_key   = i_s_axis_tdata[KEY_WIDTH-1:0];
                    n_val   = i_s_axis_tdata[32 +: VALUE_WIDTH];
                    n_slot  = i_s_axis_tdata[96 +: SLOT_W];
                    n_off   = '0;
                    n_kd    = '0;
                    n_shift = 1'b0;
                    n_ok    = 1'b0;
                    n_rv    = '0;
                    if (i_s_axis_tuser == OP_GET || i_s_axis_tuser == OP_PUT ||
                        i_s_axis_tuser == OP_REMOVE) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                n_state = S_RD;
                if (r_op == OP_PUT) begin
                    if (empty || d < r_kd) begin
                        if (r_cnt >= CNT_W'(CAPACITY)) begin
                            n_state = S_DONE;
                        end else begin
                            we         = 1'b1;
                            wdata.key  = r_key;
                            wdata.value = r_val;
                            wdata.probe = r_kd[SLOT_W-1:0];
                            n_valid[r_slot] = 1'b1;
                            if (empty) begin
                                n_cnt   = r_cnt + 1'b1;
                                n_ok    = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_key = rd.key;
                                n_val = rd.value;
                                n_kd  = d + 1'b1;
                            end
                        end
                    end else if (d == r_kd && rd.key == r_key) begin
                        we          = 1'b1;
                        wdata.value = r_val;
                        n_ok        = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        n_kd = r_kd + 1'b1;
                    end
                    if (n_state == S_RD) begin
                        n_off  = r_off + 1'b1;
                        n_slot = r_slot + 1'b1;
                        if (r_off == CNT_W'(CAPACITY - 1)) begin
                            n_state = S_DONE;
                        end
                    end
                end else if (r_shift) begin
                    // Pull the next entry back by one slot until a gap or a home entry.
                    if (empty || rd.probe == '0) begin
                        n_valid[r_a] = 1'b0;
                        n_ok         = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        we          = 1'b1;
                        waddr       = r_a;
                        wdata.probe = rd.probe - 1'b1;
                        n_a         = r_slot;
                        n_slot      = r_slot + 1'b1;
                        n_off       = r_off + 1'b1;
                        if (r_off + 2'd2 >= CNT_W'(CAPACITY)) begin
                            n_valid[r_slot] = 1'b0;
                            n_ok            = 1'b1;
                            n_state         = S_DONE;
                        end
                    end
                end else begin
                    if (empty || d < r_off) begin
                        n_rv    = (r_op == OP_GET) ? r_fb : '0;
                        n_state = S_DONE;
                    end else if (d == r_off && rd.key == r_key) begin
                        if (r_op == OP_GET) begin
                            n_ok    = 1'b1;
                            n_rv    = 32'(rd.value);
                            n_state = S_DONE;
                        end else begin
                            n_cnt   = r_cnt - 1'b1;
                            n_shift = 1'b1;
                            n_a     = r_slot;
                            n_slot  = r_slot + 1'b1;
                            if (r_off + 1'b1 >= CNT_W'(CAPACITY)) begin
                                n_valid[r_slot] = 1'b0;
                                n_ok            = 1'b1;
                                n_state         = S_DONE;
                            end
                        end
                    end else begin
                        n_off  = r_off + 1'b1;
                        n_slot = r_slot + 1'b1;
                        if (r_off == CNT_W'(CAPACITY - 1)) begin
                            n_rv    = (r_op == OP_GET) ? r_fb : '0;
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_valid  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            if (load_out) begin
                r_mvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_op <= i_s_axis_tuser;
            r_fb <= i_s_axis_tdata[95:64];
        end
        r_key   <= n_key;
        r_val   <= n_val;
        r_slot  <= n_slot;
        r_a     <= n_a;
        r_off   <= n_off;
        r_kd    <= n_kd;
        r_shift <= n_shift;
        r_ok    <= n_ok;
        r_rv    <= n_rv;
        if (load_out) begin
            r_m_rv  <= r_rv;
            r_m_cnt <= r_cnt;
            r_m_ok  <= r_ok;
        end
    end

    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = {1'b0, r_m_cnt, r_m_rv};
    assign o_m_axis_tuser  = r_m_ok;
endmodule

@@ rtl/rhh_checker.sv @@
module rhh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [39:0]  o_m_axis_tdata,
    input logic         o_m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[38:32] <= 7'd64)
        else $error("entry count above capacity");

    a_empty_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser && o_m_axis_tdata[38:32] == 7'd0 |->
            o_m_axis_tdata[31:0] == 32'd0)
        else $error("successful lookup reported with an empty table");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");
endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
